// File: src/kic_pkg.sv
// Shared types and constants for the keypad integer calculator.
// Used by the controller, the datapath and the top level; depends on nothing.
package kic_pkg;

  localparam int IN_W = 16;

  localparam logic [3:0] CMD_DIGIT  = 4'd0;
  localparam logic [3:0] CMD_SIGN   = 4'd1;
  localparam logic [3:0] CMD_BACK   = 4'd2;
  localparam logic [3:0] CMD_ADD    = 4'd3;
  localparam logic [3:0] CMD_SUB    = 4'd4;
  localparam logic [3:0] CMD_MUL    = 4'd5;
  localparam logic [3:0] CMD_DIV    = 4'd6;
  localparam logic [3:0] CMD_EQUALS = 4'd7;
  localparam logic [3:0] CMD_TOGGLE = 4'd8;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] LED_RESET = 5'd16;

  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_ADD  = 3'd1;
  localparam logic [2:0] PEND_SUB  = 3'd2;
  localparam logic [2:0] PEND_MUL  = 3'd3;
  localparam logic [2:0] PEND_DIV  = 3'd4;

  localparam int BACK_STEPS = 5;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_TOGGLE,
    DP_DIGIT,
    DP_SIGN,
    DP_LOAD_BACK,
    DP_FOLD,
    DP_STEP,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   handled;
    logic   load_out;
  } ctrl_t;

  typedef struct packed {
    logic mode_active;
    logic need_iter;
  } status_t;

endpackage

// File: src/kic_ctrl.sv
// Controller state machine of the keypad integer calculator.
// Decodes key requests and sequences the shared multiply/divide unit and the backspace steps; uses kic_pkg.
module kic_ctrl import kic_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] cmd,
  input  logic [3:0] digit,
  input  logic       pressed,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    status,
  output ctrl_t      ctrl
);

  localparam int CW = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH, S_DONE} state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          handled;
  logic          back_op;
  dp_op_t        op;
  logic          handled_dec;
  logic          load_out;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    op          = DP_IDLE;
    handled_dec = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_TOGGLE) begin
            if (pressed) begin
              op = DP_TOGGLE;
            end
          end else if (status.mode_active && cmd < CMD_TOGGLE &&
                       !(cmd == CMD_DIGIT && digit > DIGIT_MAX)) begin
            handled_dec = 1'b1;
            if (pressed) begin
              case (cmd)
                CMD_DIGIT: op = DP_DIGIT;
                CMD_SIGN:  op = DP_SIGN;
                CMD_BACK:  op = DP_LOAD_BACK;
                default:   op = DP_FOLD;
              endcase
            end
          end
        end
      end
      S_RUN:    op = DP_STEP;
      S_FINISH: op = DP_FINISH;
      default:  op = DP_IDLE;
    endcase
  end

  assign ctrl.op       = op;
  assign ctrl.handled  = handled;
  assign ctrl.load_out = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      handled   <= 1'b0;
      back_op   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            handled <= handled_dec;
            back_op <= (op == DP_LOAD_BACK);
            cnt     <= '0;
            if (op == DP_LOAD_BACK || (op == DP_FOLD && status.need_iter)) begin
              state <= S_RUN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RUN: begin
          if ((back_op && cnt == CW'(BACK_STEPS - 1)) ||
              (!back_op && cnt == CW'(VALUE_WIDTH - 1))) begin
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FINISH: state <= S_DONE;
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/kic_datapath.sv
// Datapath of the keypad integer calculator: calculator state, entry editing, a shared
// shift-add multiplier / restoring divider, a stepped divide-by-ten for backspace and the
// result register; uses kic_pkg.
module kic_datapath import kic_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [3:0]                                 cmd,
  input  logic [3:0]                                 digit,
  input  logic                                       cfg_valid,
  input  logic [4:0]                                 cfg_data,
  input  ctrl_t                                      ctrl,
  output status_t                                    status,
  output logic [((VALUE_WIDTH + 6 + 7) / 8) * 8-1:0] out_data
);

  localparam int VW    = VALUE_WIDTH;
  localparam int OUT_W = ((VALUE_WIDTH + 6 + 7) / 8) * 8;

  typedef enum logic [1:0] {U_MUL, U_DIV, U_BACK} unit_t;

  logic [4:0]    led_count;
  logic          mode_active;
  logic [VW-1:0] accumulator;
  logic [VW-2:0] entry_magnitude;
  logic          entry_negative;
  logic [2:0]    pending_operation;
  logic          showing_result;
  logic          error_sticky;

  unit_t         unit_kind;
  logic          quo_negative;
  logic [VW-1:0] rem;
  logic [VW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [2:0]    back_step;

  logic [VW-1:0] entry_value;
  logic [VW-1:0] acc_mag;
  logic [VW-1:0] val_mag;
  logic [VW-2:0] digit_base;
  logic [VW+2:0] digit_sum;
  logic [VW:0]   div_shift;
  logic [VW:0]   div_diff;
  logic [VW-1:0] back_add;
  logic [VW-1:0] back_quo;
  logic [2:0]    pending_next;
  logic [VW-1:0] shown;
  logic [VW-1:0] shown_mag;
  logic          out_of_range;
  logic [VW+5:0] payload;

  assign entry_value = entry_negative ? (VW'(0) - {1'b0, entry_magnitude})
                                      : {1'b0, entry_magnitude};
  assign acc_mag = accumulator[VW-1] ? (VW'(0) - accumulator) : accumulator;
  assign val_mag = entry_value[VW-1] ? (VW'(0) - entry_value) : entry_value;

  assign status.mode_active = mode_active;
  assign status.need_iter   = (pending_operation == PEND_MUL) ||
                              (pending_operation == PEND_DIV && entry_value != '0);

  assign digit_base = showing_result ? '0 : entry_magnitude;
  assign digit_sum  = ({4'b0, digit_base} << 3) + ({4'b0, digit_base} << 1) +
                      (VW + 3)'(digit);

  assign div_shift = {rem, quo[VW-1]};
  assign div_diff  = div_shift - {1'b0, dvs};

  // The divide by ten estimates the quotient as 0.8 times the value with shifted adds,
  // scales it by one eighth and corrects it by one when the remainder passes nine.
  always_comb begin
    case (back_step)
      3'd0:    back_add = quo >> 4;
      3'd1:    back_add = quo >> 8;
      3'd2:    back_add = quo >> 16;
      3'd3:    back_add = quo >> 32;
      default: back_add = '0;
    endcase
  end

  assign back_quo = quo >> 3;

  always_comb begin
    case (cmd)
      CMD_ADD: pending_next = PEND_ADD;
      CMD_SUB: pending_next = PEND_SUB;
      CMD_MUL: pending_next = PEND_MUL;
      CMD_DIV: pending_next = PEND_DIV;
      default: pending_next = PEND_NONE;
    endcase
  end

  assign shown        = showing_result ? accumulator : entry_value;
  assign shown_mag    = shown[VW-1] ? (VW'(0) - shown) : shown;
  assign out_of_range = error_sticky || ((shown_mag >> led_count) != '0);
  assign payload      = {out_of_range, showing_result, error_sticky, shown[VW-1], shown,
                         mode_active, ctrl.handled};

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count         <= LED_RESET;
      mode_active       <= 1'b0;
      accumulator       <= '0;
      entry_magnitude   <= '0;
      entry_negative    <= 1'b0;
      pending_operation <= PEND_NONE;
      showing_result    <= 1'b0;
      error_sticky      <= 1'b0;
      unit_kind         <= U_MUL;
      quo_negative      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        led_count <= cfg_data;
      end
      case (ctrl.op)
        DP_TOGGLE: begin
          mode_active       <= !mode_active;
          accumulator       <= '0;
          entry_magnitude   <= '0;
          entry_negative    <= 1'b0;
          pending_operation <= PEND_NONE;
          showing_result    <= 1'b0;
          error_sticky      <= 1'b0;
        end
        DP_DIGIT: begin
          if (showing_result) begin
            accumulator       <= '0;
            entry_negative    <= 1'b0;
            pending_operation <= PEND_NONE;
            showing_result    <= 1'b0;
            error_sticky      <= 1'b0;
          end
          if (digit_sum[VW+2:VW-1] == '0) begin
            entry_magnitude <= digit_sum[VW-2:0];
          end else begin
            error_sticky <= 1'b1;
          end
        end
        DP_SIGN: entry_negative <= !entry_negative;
        DP_LOAD_BACK: begin
          unit_kind <= U_BACK;
          back_step <= '0;
          dvs       <= {1'b0, entry_magnitude};
          quo       <= {2'b0, entry_magnitude[VW-2:1]} + {3'b0, entry_magnitude[VW-2:2]};
        end
        DP_FOLD: begin
          case (pending_operation)
            PEND_NONE: accumulator <= entry_value;
            PEND_ADD:  accumulator <= accumulator + entry_value;
            PEND_SUB:  accumulator <= accumulator - entry_value;
            PEND_MUL: begin
              unit_kind <= U_MUL;
              rem       <= '0;
              quo       <= entry_value;
              dvs       <= accumulator;
            end
            PEND_DIV: begin
              if (entry_value == '0) begin
                error_sticky <= 1'b1;
              end else begin
                unit_kind    <= U_DIV;
                quo_negative <= accumulator[VW-1] ^ entry_value[VW-1];
                rem          <= '0;
                quo          <= acc_mag;
                dvs          <= val_mag;
              end
            end
            default: accumulator <= accumulator;
          endcase
          entry_magnitude   <= '0;
          entry_negative    <= 1'b0;
          pending_operation <= pending_next;
          showing_result    <= (cmd == CMD_EQUALS);
        end
        DP_STEP: begin
          case (unit_kind)
            U_MUL: begin
              rem <= rem + (quo[0] ? dvs : '0);
              dvs <= dvs << 1;
              quo <= quo >> 1;
            end
            U_DIV: begin
              if (!div_diff[VW]) begin
                rem <= div_diff[VW-1:0];
                quo <= {quo[VW-2:0], 1'b1};
              end else begin
                rem <= div_shift[VW-1:0];
                quo <= {quo[VW-2:0], 1'b0};
              end
            end
            default: begin
              if (back_step == 3'(BACK_STEPS - 1)) begin
                quo <= back_quo;
                rem <= dvs - (back_quo << 3) - (back_quo << 1);
              end else begin
                quo <= quo + back_add;
              end
              back_step <= back_step + 1'b1;
            end
          endcase
        end
        DP_FINISH: begin
          case (unit_kind)
            U_MUL:   accumulator <= rem;
            U_DIV:   accumulator <= quo_negative ? (VW'(0) - quo) : quo;
            default: entry_magnitude <= quo[VW-2:0] + (VW-1)'(rem > VW'(DIGIT_MAX));
          endcase
        end
        default: mode_active <= mode_active;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_data <= OUT_W'(payload);
    end
  end

endmodule

// File: src/keypad_integer_calculator.sv
// Keypad integer calculator, top level: stream ports, controller and datapath.
// A request without a unit pass goes from acceptance straight to the result register; backspace
// first runs five divide-by-ten steps, and multiply and a nonzero divide first run the
// one-bit-per-cycle shift-add/divide unit. A request is taken only in idle, once the last
// has reached the result register; a new one is taken while a result waits at the output.
// Synchronous reset: mode off, accumulator, entry, pending operation and flags cleared, led_count 16.
module keypad_integer_calculator import kic_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // cmd [3:0], digit [7:4], pressed [8], zero [15:9]
  input  logic [IN_W-1:0]                            s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // handled, mode_on, shown_value, shown_negative, error_flag, result_shown,
  // out_of_range, then zero fill
  output logic [((VALUE_WIDTH + 6 + 7) / 8) * 8-1:0] m_axis_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [4:0]                                 cfg_data
);

  logic [3:0] cmd;
  logic [3:0] digit;
  logic       pressed;
  ctrl_t      ctrl;
  status_t    status;

  assign cmd       = s_axis_tdata[3:0];
  assign digit     = s_axis_tdata[7:4];
  assign pressed   = s_axis_tdata[8];
  assign cfg_ready = 1'b1;

  kic_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .digit     (digit),
    .pressed   (pressed),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .ctrl      (ctrl)
  );

  kic_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .digit     (digit),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for keypad_integer_calculator: drives key requests and
// led_count writes, predicts every display result and checks it. Depends on kic_pkg
// and the calculator RTL only.
module tb;
  import kic_pkg::*;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_W = ((VALUE_WIDTH + 6 + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_KEYS = 600;
  localparam longint unsigned MAX_POS = 64'h7FFF_FFFF;

  typedef struct packed {
    logic        out_of_range;
    logic        result_shown;
    logic        error_flag;
    logic        shown_negative;
    logic [31:0] shown_value;
    logic        mode_on;
    logic        handled;
  } calc_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [4:0]       cfg_data = '0;

  // Predicted calculator state.
  logic        calc_on = 1'b0;
  logic [31:0] acc = '0;
  logic [30:0] entry_mag = '0;
  logic        entry_neg = 1'b0;
  logic [2:0]  pend = PEND_NONE;
  logic        showing = 1'b0;
  logic        err = 1'b0;
  logic [4:0]  led_count_q = LED_RESET;

  calc_result_t expected_displays[$];
  int idle_pct = 0;
  int stall_left = 0;
  int stalled_cycles = 0;
  int keys_sent = 0;
  int displays_checked = 0;
  int led_writes = 0;
  int mismatches = 0;

  keypad_integer_calculator #(.VALUE_WIDTH(VALUE_WIDTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int rand_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic void clear_calc();
    acc = '0;
    entry_mag = '0;
    entry_neg = 1'b0;
    pend = PEND_NONE;
    showing = 1'b0;
    err = 1'b0;
  endfunction

  function automatic logic [31:0] signed_entry();
    return entry_neg ? -{1'b0, entry_mag} : {1'b0, entry_mag};
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic calc_result_t apply_key(input logic [3:0] cmd, input logic [3:0] dig,
                                             input logic pressed);
    calc_result_t r;
    logic [31:0] operand;
    logic [31:0] shown;
    logic [31:0] quot;
    longint unsigned m;
    r = '0;
    if (cmd == CMD_TOGGLE) begin
      if (pressed) begin
        calc_on = !calc_on;
        clear_calc();
      end
    end else if (calc_on && cmd < CMD_TOGGLE && !(cmd == CMD_DIGIT && dig > DIGIT_MAX)) begin
      r.handled = 1'b1;
      if (pressed) begin
        if (cmd == CMD_DIGIT) begin
          if (showing) clear_calc();
          m = entry_mag;
          if (m <= (MAX_POS - dig) / 10) entry_mag = 31'(m * 10 + dig);
          else err = 1'b1;
        end else if (cmd == CMD_SIGN) begin
          entry_neg = !entry_neg;
        end else if (cmd == CMD_BACK) begin
          entry_mag = entry_mag / 10;
        end else begin
          operand = signed_entry();
          case (pend)
            PEND_NONE: acc = operand;
            PEND_ADD:  acc = acc + operand;
            PEND_SUB:  acc = acc - operand;
            PEND_MUL:  acc = acc * operand;
            PEND_DIV: begin
              if (operand == '0) begin
                err = 1'b1;
              end else begin
                quot = abs32(acc) / abs32(operand);
                acc = (acc[31] ^ operand[31]) ? -quot : quot;
              end
            end
            default: ;
          endcase
          entry_mag = '0;
          entry_neg = 1'b0;
          showing = (cmd == CMD_EQUALS);
          case (cmd)
            CMD_ADD: pend = PEND_ADD;
            CMD_SUB: pend = PEND_SUB;
            CMD_MUL: pend = PEND_MUL;
            CMD_DIV: pend = PEND_DIV;
            default: pend = PEND_NONE;
          endcase
        end
      end
    end
    shown = showing ? acc : signed_entry();
    r.mode_on = calc_on;
    r.shown_value = shown;
    r.shown_negative = shown[31];
    r.error_flag = err;
    r.result_shown = showing;
    r.out_of_range = err || (64'(abs32(shown)) >= (64'd1 << led_count_q));
    return r;
  endfunction

  function automatic string describe(input calc_result_t r);
    return $sformatf("handled=%b mode_on=%b value=%0d negative=%b error=%b result=%b oor=%b",
                     r.handled, r.mode_on, $signed(r.shown_value), r.shown_negative,
                     r.error_flag, r.result_shown, r.out_of_range);
  endfunction

  task automatic send_key(input logic [3:0] cmd, input logic [3:0] dig, input logic pressed);
    int gap;
    @(negedge clk);
    gap = rand_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {7'b0, pressed, dig, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_displays.push_back(apply_key(cmd, dig, pressed));
    keys_sent++;
  endtask

  task automatic press(input logic [3:0] cmd, input logic [3:0] dig);
    send_key(cmd, dig, 1'b1);
    if ($urandom_range(0, 5) == 0) send_key(cmd, dig, 1'b0);
  endtask

  task automatic enter_number(input longint unsigned v);
    int unsigned digs[$];
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) press(CMD_DIGIT, 4'(digs[i]));
  endtask

  task automatic drain_displays();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
  endtask

  task automatic write_led_count(input logic [4:0] value);
    drain_displays();
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    led_count_q = value;
    led_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_mode_off();
    press(CMD_DIGIT, 4'd5);
    send_key(CMD_ADD, 4'd0, 1'b1);
    send_key(4'hF, 4'hF, 1'b1);
    send_key(CMD_TOGGLE, 4'd0, 1'b0);
    send_key(CMD_TOGGLE, 4'd0, 1'b1);
  endtask

  task automatic test_entry_edits();
    send_key(CMD_DIGIT, 4'd12, 1'b1);
    send_key(CMD_DIGIT, 4'hF, 1'b1);
    send_key(4'd9, 4'd3, 1'b1);
    send_key(CMD_DIGIT, 4'd8, 1'b0);
    enter_number(64'd2147483647);
    send_key(CMD_DIGIT, 4'd0, 1'b1);
    send_key(CMD_SIGN, 4'd0, 1'b1);
    send_key(CMD_BACK, 4'd0, 1'b1);
    send_key(CMD_TOGGLE, 4'd0, 1'b1);
    send_key(CMD_TOGGLE, 4'd0, 1'b1);
  endtask

  task automatic test_arith_corners();
    // Build the most negative value, then divide it by minus one.
    enter_number(64'd2147483647);
    send_key(CMD_SIGN, 4'd0, 1'b1);
    send_key(CMD_SUB, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd1, 1'b1);
    send_key(CMD_DIV, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd1, 1'b1);
    send_key(CMD_SIGN, 4'd0, 1'b1);
    send_key(CMD_EQUALS, 4'd0, 1'b1);
    send_key(CMD_SIGN, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd8, 1'b1);
    send_key(CMD_MUL, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd9, 1'b1);
    send_key(CMD_ADD, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd3, 1'b1);
    send_key(CMD_DIV, 4'd0, 1'b1);
    send_key(CMD_EQUALS, 4'd0, 1'b1);
    send_key(CMD_DIGIT, 4'd6, 1'b1);
  endtask

  task automatic random_sequence();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!calc_on && r < 85) begin
      press(CMD_TOGGLE, 4'($urandom_range(0, 15)));
    end else if (r < 6) begin
      send_key(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end else if (r < 9) begin
      press(CMD_TOGGLE, 4'd0);
    end else begin
      r = $urandom_range(0, 99);
      n = (r < 70) ? $urandom_range(0, 3) : (r < 90) ? $urandom_range(4, 9)
                                                     : $urandom_range(10, 12);
      repeat (n) press(CMD_DIGIT, 4'($urandom_range(0, 9)));
      if ($urandom_range(0, 4) == 0) press(CMD_SIGN, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) == 0) press(CMD_BACK, 4'($urandom_range(0, 15)));
      press(4'($urandom_range(CMD_ADD, CMD_EQUALS)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_random_sessions();
    logic [4:0] leds[6];
    int pcts[6];
    int start;
    leds = '{5'd1, 5'd31, 5'd16, 5'd5, 5'd10, 5'($urandom_range(1, 31))};
    pcts = '{0, 40, 20, 70, 0, 30};
    foreach (leds[p]) begin
      write_led_count(leds[p]);
      idle_pct = pcts[p];
      start = keys_sent;
      while (keys_sent - start < RANDOM_KEYS / 6) random_sequence();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      int gap;
      gap = rand_gap();
      stall_left <= (gap > 0) ? gap - 1 : 0;
      m_axis_tready <= (gap == 0);
    end
  end

  always @(posedge clk) begin : check_displays
    calc_result_t got;
    calc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[37:0];
      displays_checked++;
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Display result with no request pending: %s", describe(got));
      end else begin
        want = expected_displays.pop_front();
        if (got.handled !== want.handled || got.mode_on !== want.mode_on ||
            got.shown_value !== want.shown_value || got.shown_negative !== want.shown_negative ||
            got.error_flag !== want.error_flag || got.result_shown !== want.result_shown ||
            got.out_of_range !== want.out_of_range) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Display result %0d expected: %s", displays_checked, describe(want));
            $display("Display result %0d actual:   %s", displays_checked, describe(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_mode_off();
    write_led_count(5'd31);
    test_entry_edits();
    write_led_count(5'd1);
    test_arith_corners();
    test_random_sessions();
    drain_displays();
    repeat (40) @(posedge clk);
    mismatches += expected_displays.size();
    $display("Sent %0d key requests and checked %0d display results over %0d led_count writes.",
             keys_sent, displays_checked, led_writes);
    $display("Mismatches counted: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
